### rtl/gbn_pkg.sv
package gbn_pkg;

    // Field widths fixed by the interface.
    localparam int SEQ_W     = 16;
    localparam int FILE_W    = 24;
    localparam int LEN_W     = 11;
    localparam int WIN_W     = 6;
    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Defaults for the top-level parameters. The segment size must be a
    // power of two.
    localparam int SEGMENT_BYTES_DEF = 1024;
    localparam int MAX_WINDOW_DEF    = 32;

    // Register reset values.
    localparam logic [WIN_W-1:0]  WINDOW_RESET  = WIN_W'(8);
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(1000);

    // Identical acks beyond the first that trigger a fast retransmit.
    localparam logic [1:0] DUP_LIMIT = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILE_SIZE     = 2'd0,
        REG_WINDOW_SIZE   = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_RESEND,
        ST_ACK
    } gbn_state_t;

    typedef enum logic [1:0] {
        ISSUE_NEW,
        ISSUE_RETX,
        ISSUE_DONE
    } issue_kind_t;

    typedef struct packed {
        logic        accept;
        logic        tick_commit;
        logic        ack_commit;
        logic        resend_step;
        logic        issue;
        issue_kind_t kind;
        logic        issue_last;
    } gbn_cmd_t;

    typedef struct packed {
        logic finished;
        logic operation;
        logic send_ok;
        logic resend_more;
        logic resend_final;
        logic issue_ready;
        logic ack_usable;
        logic ack_final;
    } gbn_status_t;

endpackage

### rtl/gbn_ifs.sv
interface gbn_item_if
    import gbn_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [SEQ_W-1:0] ack_number;
    logic             ack_check_ok;

    modport source (output valid, output operation, output ack_number,
                    output ack_check_ok, input ready);
    modport sink   (input valid, input operation, input ack_number,
                    input ack_check_ok, output ready);
endinterface

interface gbn_result_if
    import gbn_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  send_seq;
    logic [FILE_W-1:0] byte_offset;
    logic [LEN_W-1:0]  byte_length;
    logic              is_header;
    logic              is_retransmit;
    logic              transfer_done;
    logic              last;

    modport source (output valid, output send_seq, output byte_offset,
                    output byte_length, output is_header, output is_retransmit,
                    output transfer_done, output last, input ready);
    modport sink   (input valid, input send_seq, input byte_offset,
                    input byte_length, input is_header, input is_retransmit,
                    input transfer_done, input last, output ready);
endinterface

interface gbn_cfg_if
    import gbn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/gbn_ctrl.sv
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  gbn_status_t status,
    output gbn_cmd_t    cmd
);

    gbn_state_t state_reg;
    gbn_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = status.operation ? ST_ACK : ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (status.finished)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.send_ok || status.issue_ready)
                begin
                    state_next = status.resend_more ? ST_RESEND : ST_IDLE;
                end
            end
            ST_RESEND:
            begin
                if (status.issue_ready && status.resend_final)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (status.finished || !status.ack_usable || !status.ack_final ||
                    status.issue_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands. The operation bit seen in IDLE is the one on the item port,
    // which the datapath passes through until the item is latched.
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.accept = item_valid;
            end
            ST_TICK:
            begin
                if (!status.finished)
                begin
                    if (!status.send_ok)
                    begin
                        cmd.tick_commit = 1'b1;
                    end
                    else if (status.issue_ready)
                    begin
                        cmd.tick_commit = 1'b1;
                        cmd.issue       = 1'b1;
                        cmd.kind        = ISSUE_NEW;
                        cmd.issue_last  = !status.resend_more;
                    end
                end
            end
            ST_RESEND:
            begin
                if (status.issue_ready)
                begin
                    cmd.issue       = 1'b1;
                    cmd.kind        = ISSUE_RETX;
                    cmd.issue_last  = status.resend_final;
                    cmd.resend_step = 1'b1;
                end
            end
            ST_ACK:
            begin
                if (!status.finished && status.ack_usable)
                begin
                    if (!status.ack_final)
                    begin
                        cmd.ack_commit = 1'b1;
                    end
                    else if (status.issue_ready)
                    begin
                        cmd.ack_commit = 1'b1;
                        cmd.issue      = 1'b1;
                        cmd.kind       = ISSUE_DONE;
                        cmd.issue_last = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/gbn_datapath.sv
module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gbn_cmd_t             cmd,
    output gbn_status_t          status,
    input  logic                 item_operation,
    input  logic [SEQ_W-1:0]     item_ack_number,
    input  logic                 item_ack_check_ok,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 res_ready,
    output logic                 res_valid,
    output logic [SEQ_W-1:0]     res_send_seq,
    output logic [FILE_W-1:0]    res_byte_offset,
    output logic [LEN_W-1:0]     res_byte_length,
    output logic                 res_is_header,
    output logic                 res_is_retransmit,
    output logic                 res_transfer_done,
    output logic                 res_last
);

    localparam int SEG_W     = $clog2(SEGMENT_BYTES);
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int WIN_EXT_W = ((WIN_W + 1) > CNT_W) ? (WIN_W + 1) : CNT_W;

    // Configuration.
    logic [FILE_W-1:0] file_size_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [TICK_W-1:0] timeout_reg;

    // Segment count. The segment size is a power of two, so the number of
    // full segments and the remainder are a shift and a mask of the file size.
    logic [FILE_W-1:0] seg_full;
    logic [SEG_W-1:0]  seg_rem;
    logic [FILE_W:0]   total_sum;
    logic [SEQ_W-1:0]  total_seg;

    // Protocol state.
    logic [SEQ_W-1:0]  base_reg,      base_next;
    logic [SEQ_W-1:0]  next_seq_reg,  next_seq_next;
    logic [TICK_W-1:0] elapsed_reg,   elapsed_next;
    logic [SEQ_W-1:0]  prev_ack_reg,  prev_ack_next;
    logic              prev_ok_reg,   prev_ok_next;
    logic [1:0]        dup_reg,       dup_next;
    logic              fast_reg,      fast_next;
    logic              finished_reg,  finished_next;
    logic [CNT_W-1:0]  idx_reg,       idx_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;

    // Latched item.
    logic              op_reg;
    logic [SEQ_W-1:0]  ack_reg;
    logic              ack_ok_reg;

    // Tick evaluation.
    logic [WIN_EXT_W-1:0] win_ext;
    logic [WIN_EXT_W-1:0] eff_win;
    logic [SEQ_W:0]       win_limit;
    logic                 send_ok;
    logic [TICK_W-1:0]    elapsed_inc;
    logic [TICK_W-1:0]    elapsed_sent;
    logic [SEQ_W-1:0]     next_sent;
    logic                 resend_go;
    logic [SEQ_W-1:0]     outstanding;
    logic [CNT_W-1:0]     resend_cnt;
    logic [CNT_W-1:0]     idx_inc;

    // Ack evaluation.
    logic [SEQ_W-1:0]  new_base;
    logic              ack_final;

    // Issue stage and output register.
    logic              s1_valid_reg,  s1_valid_next;
    logic [SEQ_W-1:0]  s1_seq_reg;
    logic              s1_retx_reg;
    logic              s1_done_reg;
    logic              s1_last_reg;
    logic              s1_move;
    logic              issue_ready;
    logic [SEQ_W-1:0]  issue_seq;
    logic              res_valid_reg, res_valid_next;
    logic [31:0]       offset_prod;
    logic [31:0]       length_full;
    logic [FILE_W:0]   last_seg_seq;
    logic [SEQ_W-1:0]  seq_m1;

    // ---------------- configuration and segment count ----------------
    always_comb
    begin
        seg_full  = file_size_reg >> SEG_W;
        seg_rem   = file_size_reg[SEG_W-1:0];
        total_sum = (FILE_W+1)'(seg_full) +
                    ((seg_rem != '0) ? (FILE_W+1)'(2) : (FILE_W+1)'(1));
        total_seg = (total_sum > (FILE_W+1)'({SEQ_W{1'b1}})) ?
                    {SEQ_W{1'b1}} : total_sum[SEQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            window_reg    <= WINDOW_RESET;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FILE_SIZE:
                begin
                    file_size_reg <= cfg_data[FILE_W-1:0];
                end
                REG_WINDOW_SIZE:
                begin
                    window_reg <= cfg_data[WIN_W-1:0];
                end
                REG_TIMEOUT_TICKS:
                begin
                    timeout_reg <= cfg_data[TICK_W-1:0];
                end
                default:
                begin
                    window_reg <= window_reg;
                end
            endcase
        end
    end

    // ---------------- tick and ack evaluation ----------------
    always_comb
    begin
        win_ext = WIN_EXT_W'(window_reg);
        if (win_ext == '0)
        begin
            eff_win = WIN_EXT_W'(1);
        end
        else if (win_ext > WIN_EXT_W'(MAX_WINDOW))
        begin
            eff_win = WIN_EXT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = win_ext;
        end
        win_limit    = {1'b0, base_reg} + (SEQ_W+1)'(eff_win);
        send_ok      = ({1'b0, next_seq_reg} < win_limit) && (next_seq_reg < total_seg);
        elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TICK_W'(1);
        elapsed_sent = (send_ok && (base_reg == next_seq_reg)) ? '0 : elapsed_inc;
        next_sent    = send_ok ? next_seq_reg + SEQ_W'(1) : next_seq_reg;
        resend_go    = (elapsed_sent >= timeout_reg) || fast_reg;
        outstanding  = next_sent - base_reg;
        resend_cnt   = (outstanding > SEQ_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                          : outstanding[CNT_W-1:0];
        idx_inc      = idx_reg + CNT_W'(1);

        new_base  = (ack_reg >= base_reg) ? ack_reg + SEQ_W'(1) : base_reg;
        ack_final = ({1'b0, ack_reg} + (SEQ_W+1)'(1)) == {1'b0, total_seg};
    end

    always_comb
    begin
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        elapsed_next  = elapsed_reg;
        prev_ack_next = prev_ack_reg;
        prev_ok_next  = prev_ok_reg;
        dup_next      = dup_reg;
        fast_next     = fast_reg;
        finished_next = finished_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        if (cmd.tick_commit)
        begin
            next_seq_next = next_sent;
            elapsed_next  = resend_go ? '0 : elapsed_sent;
            if (resend_go)
            begin
                fast_next = 1'b0;
            end
            idx_next = '0;
            cnt_next = resend_cnt;
        end
        if (cmd.resend_step)
        begin
            idx_next = idx_inc;
        end
        if (cmd.ack_commit)
        begin
            base_next = new_base;
            if (new_base != next_seq_reg)
            begin
                elapsed_next = '0;
            end
            if (ack_final)
            begin
                finished_next = 1'b1;
            end
            else if (!prev_ok_reg || (prev_ack_reg != ack_reg))
            begin
                prev_ack_next = ack_reg;
                prev_ok_next  = 1'b1;
                dup_next      = '0;
            end
            else if (dup_reg < DUP_LIMIT)
            begin
                dup_next = dup_reg + 2'd1;
                if (dup_reg + 2'd1 == DUP_LIMIT)
                begin
                    fast_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            next_seq_reg <= '0;
            elapsed_reg  <= '0;
            prev_ack_reg <= '0;
            prev_ok_reg  <= 1'b0;
            dup_reg      <= '0;
            fast_reg     <= 1'b0;
            finished_reg <= 1'b0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            elapsed_reg  <= elapsed_next;
            prev_ack_reg <= prev_ack_next;
            prev_ok_reg  <= prev_ok_next;
            dup_reg      <= dup_next;
            fast_reg     <= fast_next;
            finished_reg <= finished_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= item_operation;
            ack_reg    <= item_ack_number;
            ack_ok_reg <= item_ack_check_ok;
        end
    end

    // ---------------- issue stage and output register ----------------
    always_comb
    begin
        s1_move        = s1_valid_reg && (!res_valid_reg || res_ready);
        issue_ready    = !s1_valid_reg || s1_move;
        s1_valid_next  = cmd.issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        res_valid_next = s1_move ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
        case (cmd.kind)
            ISSUE_NEW:  issue_seq = next_seq_reg;
            ISSUE_RETX: issue_seq = base_reg + SEQ_W'(idx_reg);
            default:    issue_seq = '0;
        endcase

        seq_m1       = s1_seq_reg - SEQ_W'(1);
        offset_prod  = 32'(seq_m1) * 32'(SEGMENT_BYTES);
        last_seg_seq = (FILE_W+1)'(seg_full) + (FILE_W+1)'(1);
        if (((FILE_W+1)'(s1_seq_reg) == last_seg_seq) && (seg_rem != '0))
        begin
            length_full = 32'(seg_rem);
        end
        else
        begin
            length_full = 32'(SEGMENT_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            s1_seq_reg  <= issue_seq;
            s1_retx_reg <= (cmd.kind == ISSUE_RETX);
            s1_done_reg <= (cmd.kind == ISSUE_DONE);
            s1_last_reg <= cmd.issue_last;
        end
        if (s1_move)
        begin
            res_send_seq      <= s1_done_reg ? '0 : s1_seq_reg;
            res_is_header     <= !s1_done_reg && (s1_seq_reg == '0);
            res_is_retransmit <= s1_retx_reg;
            res_transfer_done <= s1_done_reg;
            res_last          <= s1_last_reg;
            if (s1_done_reg || (s1_seq_reg == '0))
            begin
                res_byte_offset <= '0;
                res_byte_length <= '0;
            end
            else
            begin
                res_byte_offset <= offset_prod[FILE_W-1:0];
                res_byte_length <= length_full[LEN_W-1:0];
            end
        end
    end

    assign res_valid = res_valid_reg;

    always_comb
    begin
        status.finished     = finished_reg;
        // In IDLE the item is not latched yet, so the port value steers the branch.
        status.operation    = cmd.accept ? item_operation : op_reg;
        status.send_ok      = send_ok;
        status.resend_more  = resend_go && (resend_cnt != '0);
        status.resend_final = idx_inc == cnt_reg;
        status.issue_ready  = issue_ready;
        status.ack_usable   = ack_ok_reg && (ack_reg < next_seq_reg);
        status.ack_final    = ack_final;
    end

endmodule

### rtl/go_back_n_sender_window.sv
// Go-Back-N sender window control with fast retransmit. Each accepted item is
// either a tick (send opportunity and timer advance) or a received ack; the
// block answers with zero or more result transactions, each naming one segment
// to transmit (sequence number, file offset and length) or, once, reporting
// that the final segment was acknowledged. The last result of an item carries
// last. An item is accepted, then evaluated, and a window resend then issues
// its resent segments one at a time; results leave through a two-register
// output path at one per cycle when the sink is ready, and while that path is
// full the item waits for the sink. The item port is ready only between
// items. All registers take effect at once; the segment size must be a power
// of two, so the segment count is a shift and a mask of file_size.
module go_back_n_sender_window
    import gbn_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    gbn_item_if.sink     item,
    gbn_result_if.source result,
    gbn_cfg_if.sink      cfg
);

    gbn_cmd_t    cmd;
    gbn_status_t status;

    // The controller sequences each item; the datapath holds the window
    // state, the segment count and the result pipeline.
    gbn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    gbn_datapath #(
        .SEGMENT_BYTES (SEGMENT_BYTES),
        .MAX_WINDOW    (MAX_WINDOW)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .item_operation    (item.operation),
        .item_ack_number   (item.ack_number),
        .item_ack_check_ok (item.ack_check_ok),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .res_ready         (result.ready),
        .res_valid         (result.valid),
        .res_send_seq      (result.send_seq),
        .res_byte_offset   (result.byte_offset),
        .res_byte_length   (result.byte_length),
        .res_is_header     (result.is_header),
        .res_is_retransmit (result.is_retransmit),
        .res_transfer_done (result.transfer_done),
        .res_last          (result.last)
    );

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

endmodule

### rtl/gbn_checker.sv
module gbn_checker
    import gbn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [SEQ_W-1:0]  res_send_seq,
    input logic [FILE_W-1:0] res_byte_offset,
    input logic [LEN_W-1:0]  res_byte_length,
    input logic              res_is_header,
    input logic              res_is_retransmit,
    input logic              res_transfer_done,
    input logic              res_last
);

    logic done_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
        end
        else if (res_valid && res_ready && res_transfer_done)
        begin
            done_seen_reg <= 1'b1;
        end
    end

    // The done report carries no segment and closes its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_transfer_done |-> res_last && (res_send_seq == '0) &&
        (res_byte_offset == '0) && (res_byte_length == '0) &&
        !res_is_header && !res_is_retransmit)
        else $error("done result carries segment fields");

    // Nothing follows the done report until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_seen_reg |-> !res_valid)
        else $error("result after transfer done");

    // One item at a time: the item port closes right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted in back-to-back cycles");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_send_seq) &&
        $stable(res_last))
        else $error("stalled result changed");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .res_send_seq      (result.send_seq),
    .res_byte_offset   (result.byte_offset),
    .res_byte_length   (result.byte_length),
    .res_is_header     (result.is_header),
    .res_is_retransmit (result.is_retransmit),
    .res_transfer_done (result.transfer_done),
    .res_last          (result.last)
);

### bench/go_back_n_sender_window_test.sv
`timescale 1ns / 100ps

module go_back_n_sender_window_test;
    import gbn_pkg::*;

    localparam int     CLK_HALF_NS   = 4;
    localparam int     SEG_BYTES     = SEGMENT_BYTES_DEF;
    localparam int     WINDOW_CAP    = MAX_WINDOW_DEF;
    localparam int     PHASE_ITEMS   = 16;
    localparam int     RANDOM_PHASES = 5;
    localparam int     PRESSURE_PH   = 4;
    localparam int     PAUSE_PH      = 1;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     TAIL_CYCLES   = 40;
    localparam int     FINALE_GUARD  = 400;
    localparam longint LIMIT_NS      = 4_000_000;

    // Item operations.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One input transaction: a tick or a received ack.
    typedef struct packed {
        logic             op;
        logic [SEQ_W-1:0] ack;
        logic             ok;
    } gbn_event_t;

    // One result transaction: a segment to put on the wire, or the done marker.
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [FILE_W-1:0] offset;
        logic [LEN_W-1:0]  length;
        logic              header;
        logic              retx;
        logic              done;
        logic              last;
    } segment_t;

    // A row of the directed script. A row either writes a register or sends an
    // event; where the outcome is obvious the expected segment is written here
    // by hand instead of being taken from the window model below.
    typedef struct packed {
        logic                 write_reg;
        reg_index_t           reg_sel;
        logic [CFG_DAT_W-1:0] reg_value;
        gbn_event_t           ev;
        logic                 by_hand;
        logic                 hand_count;
        segment_t             hand_seg;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    gbn_item_if   item_ch ();
    gbn_result_if result_ch ();
    gbn_cfg_if    cfg_ch ();

    go_back_n_sender_window u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #CLK_HALF_NS clk = ~clk;

    // Register copies kept by the window model.
    logic [FILE_W-1:0] file_size_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [TICK_W-1:0] timeout_reg;

    // Sender state kept by the window model.
    logic [31:0]       base_seq;
    logic [31:0]       next_unsent;
    logic [TICK_W-1:0] idle_ticks;
    logic [SEQ_W-1:0]  last_ack;
    logic              last_ack_seen;
    logic [1:0]        dup_acks;
    logic              fast_pending;
    logic              transfer_over;

    segment_t    step_segs[$];     // segments caused by the event just accepted
    segment_t    pending_segs[$];  // segments still owed by the block, oldest first
    script_row_t script[$];

    idle_mode_t idle_mode = IDLE_NONE;
    int         fail_count = 0;
    int         hold_asked = 0;
    int         hold_served = 0;
    int         hold_left = 0;

    // Header plus full segments plus one partial segment if there is a remainder.
    function automatic logic [31:0] segment_total();
        logic [31:0] full;
        logic [31:0] rem;
        logic [31:0] t;
        full = 32'(file_size_reg) / SEG_BYTES;
        rem  = 32'(file_size_reg) % SEG_BYTES;
        t    = full + (rem > 0 ? 32'd2 : 32'd1);
        return (t > 32'd65535) ? 32'd65535 : t;
    endfunction

    // The window register is clamped into 1..WINDOW_CAP.
    function automatic logic [31:0] eff_window();
        logic [31:0] w;
        w = 32'(window_reg);
        if (w < 1) w = 1;
        if (w > WINDOW_CAP) w = WINDOW_CAP;
        return w;
    endfunction

    function automatic segment_t make_segment(input logic [31:0] seq, input logic retx);
        segment_t    s;
        logic [31:0] full;
        logic [31:0] rem;
        logic [31:0] off;
        logic [31:0] len;
        full = 32'(file_size_reg) / SEG_BYTES;
        rem  = 32'(file_size_reg) % SEG_BYTES;
        off  = 0;
        len  = 0;
        if (seq != 0) begin
            off = (seq - 1) * SEG_BYTES;
            len = (seq == full + 1 && rem > 0) ? rem : SEG_BYTES;
        end
        s        = '0;
        s.seq    = seq[SEQ_W-1:0];
        s.offset = off[FILE_W-1:0];
        s.length = len[LEN_W-1:0];
        s.header = (seq == 0);
        s.retx   = retx;
        return s;
    endfunction

    // Window model: updates the sender state for one accepted event and leaves
    // the segments it causes in step_segs.
    function automatic void predict_event(input gbn_event_t ev);
        logic [31:0] total;
        logic [31:0] span;
        logic [31:0] ackw;
        segment_t    s;
        total = segment_total();
        ackw  = 32'(ev.ack);
        step_segs = {};
        if (transfer_over) return;

        if (ev.op == OP_TICK) begin
            if (idle_ticks != '1) idle_ticks = idle_ticks + 1;
            if (next_unsent < base_seq + eff_window() && next_unsent < total) begin
                step_segs.push_back(make_segment(next_unsent, 1'b0));
                if (base_seq == next_unsent) idle_ticks = '0;
                next_unsent = next_unsent + 1;
            end
            // A timeout or a pending fast retransmit resends the whole window,
            // even when nothing is outstanding the timer and flag still clear.
            if (idle_ticks >= timeout_reg || fast_pending) begin
                span = (next_unsent > base_seq) ? next_unsent - base_seq : 0;
                if (span > WINDOW_CAP) span = WINDOW_CAP;
                for (int i = 0; i < span; i++)
                    step_segs.push_back(make_segment(base_seq + i, 1'b1));
                idle_ticks   = '0;
                fast_pending = 1'b0;
            end
            if (step_segs.size() > 0) begin
                s = step_segs.pop_back();
                s.last = 1'b1;
                step_segs.push_back(s);
            end
            return;
        end

        // Acks with a bad checksum or for a segment never sent are dropped.
        if (!ev.ok || ackw >= next_unsent) return;

        // Cumulative ack; a stale one leaves the base alone but still counts.
        if (ackw >= base_seq) base_seq = ackw + 1;
        if (base_seq != next_unsent) idle_ticks = '0;

        if (ackw + 1 == total) begin
            transfer_over = 1'b1;
            s      = '0;
            s.done = 1'b1;
            s.last = 1'b1;
            step_segs.push_back(s);
            return;
        end

        // Only the fourth identical ack in a row arms the fast retransmit.
        if (!last_ack_seen || last_ack != ev.ack) begin
            last_ack      = ev.ack;
            last_ack_seen = 1'b1;
            dup_acks      = '0;
        end else if (dup_acks < DUP_LIMIT) begin
            dup_acks = dup_acks + 2'd1;
            if (dup_acks == DUP_LIMIT) fast_pending = 1'b1;
        end
    endfunction

    function automatic void apply_reg(input reg_index_t r, input logic [CFG_DAT_W-1:0] v);
        case (r)
            REG_FILE_SIZE:     file_size_reg = v[FILE_W-1:0];
            REG_WINDOW_SIZE:   window_reg    = v[WIN_W-1:0];
            REG_TIMEOUT_TICKS: timeout_reg   = v[TICK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic script_row_t reg_row(input reg_index_t r, input logic [31:0] v);
        script_row_t row;
        row           = '0;
        row.write_reg = 1'b1;
        row.reg_sel   = r;
        row.reg_value = v;
        return row;
    endfunction

    function automatic script_row_t ev_row(input logic op, input logic [SEQ_W-1:0] ack,
                                           input logic ok);
        script_row_t row;
        row        = '0;
        row.ev.op  = op;
        row.ev.ack = ack;
        row.ev.ok  = ok;
        return row;
    endfunction

    // A row whose outcome is written by hand: no segment, or exactly one.
    function automatic script_row_t hand_row(input logic op, input logic [SEQ_W-1:0] ack,
                                             input logic ok, input logic cnt,
                                             input segment_t s);
        script_row_t row;
        row            = ev_row(op, ack, ok);
        row.by_hand    = 1'b1;
        row.hand_count = cnt;
        row.hand_seg   = s;
        return row;
    endfunction

    function automatic segment_t lone_seg(input logic [SEQ_W-1:0] seq,
                                          input logic [FILE_W-1:0] off,
                                          input logic [LEN_W-1:0] len,
                                          input logic hdr, input logic retx);
        segment_t s;
        s        = '0;
        s.seq    = seq;
        s.offset = off;
        s.length = len;
        s.header = hdr;
        s.retx   = retx;
        s.last   = 1'b1;
        return s;
    endfunction

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 56;
            IDLE_BOTH:   return $urandom_range(0, 99) < 7;
            default:     return 1'b0;
        endcase
    endfunction

    // Random event. Most are well-formed acks near the window or ticks; the
    // rest are arbitrary acks, mostly out of range or with a bad checksum.
    // Before the closing phase an ack that would finish the transfer is
    // pulled back, since finishing is sticky until reset.
    function automatic gbn_event_t pick_event(input bit finale);
        gbn_event_t  ev;
        logic [31:0] lo;
        int          roll;
        roll   = $urandom_range(0, 99);
        ev.op  = OP_TICK;
        ev.ack = SEQ_W'($urandom);
        ev.ok  = 1'($urandom_range(0, 1));
        if (roll < 15) begin
            ev.op = OP_ACK;
        end else if (roll < 55 && next_unsent != 0) begin
            ev.op = OP_ACK;
            ev.ok = 1'b1;
            lo = (base_seq > 3) ? base_seq - 3 : 0;
            if (last_ack_seen && roll < 30 && 32'(last_ack) < next_unsent)
                ev.ack = last_ack;
            else
                ev.ack = SEQ_W'($urandom_range(next_unsent - 1, lo));
        end
        if (!finale && ev.op == OP_ACK && ev.ok && 32'(ev.ack) < next_unsent &&
            32'(ev.ack) + 1 == segment_total()) begin
            if (ev.ack != 0) ev.ack = ev.ack - SEQ_W'(1);
            else ev.op = OP_TICK;
        end
        return ev;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one event, hold it until the block takes it, then record what it
    // should produce. Valid stays high into the next event unless the sender
    // decides to idle.
    task automatic send_event(input gbn_event_t ev, input logic by_hand,
                              input logic hand_count, input segment_t hand_seg);
        while (sender_pauses()) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= ev.op;
        item_ch.ack_number   <= ev.ack;
        item_ch.ack_check_ok <= ev.ok;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        predict_event(ev);
        if (by_hand) begin
            if (hand_count) pending_segs.push_back(hand_seg);
        end else begin
            foreach (step_segs[i]) pending_segs.push_back(step_segs[i]);
        end
    endtask

    // Stop offering, let every owed segment come out, then allow a few more
    // cycles for an event that produces nothing to finish inside the block.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Valid is left high so back-to-back writes follow each other directly; the
    // caller lowers it once the last write has gone through.
    task automatic write_reg(input reg_index_t r, input logic [CFG_DAT_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        apply_reg(r, v);
    endtask

    // Result side: check every accepted segment against the oldest one owed,
    // then decide ready for the next cycle. A hold request from the stimulus
    // keeps ready low for a long stretch so the block backs up.
    initial begin
        segment_t got;
        segment_t want;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got.seq    = result_ch.send_seq;
                got.offset = result_ch.byte_offset;
                got.length = result_ch.byte_length;
                got.header = result_ch.is_header;
                got.retx   = result_ch.is_retransmit;
                got.done   = result_ch.transfer_done;
                got.last   = result_ch.last;
                if (pending_segs.size() == 0) begin
                    $error("unexpected result transaction: send_seq %0h", got.seq);
                    fail_count++;
                end else begin
                    want = pending_segs.pop_front();
                    check_field("send_seq", 32'(want.seq), 32'(got.seq));
                    check_field("byte_offset", 32'(want.offset), 32'(got.offset));
                    check_field("byte_length", 32'(want.length), 32'(got.length));
                    check_field("is_header", 32'(want.header), 32'(got.header));
                    check_field("is_retransmit", 32'(want.retx), 32'(got.retx));
                    check_field("transfer_done", 32'(want.done), 32'(got.done));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (hold_asked != hold_served) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_asked;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                case (idle_mode)
                    IDLE_RECEIVER: result_ch.ready <= ($urandom_range(0, 99) >= 56);
                    IDLE_BOTH:     result_ch.ready <= ($urandom_range(0, 99) >= 7);
                    default:       result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus: directed script first, then random phases that each pick new
    // register values, then a closing phase that drives the transfer to done.
    initial begin
        script_row_t row;
        gbn_event_t  ev;
        logic        prev_cfg;
        logic [31:0] target;
        logic [31:0] fsize;
        logic [31:0] win;
        logic [31:0] tmo;
        int          guard;

        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.operation    <= OP_TICK;
        item_ch.ack_number   <= '0;
        item_ch.ack_check_ok <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_FILE_SIZE;
        cfg_ch.data          <= '0;

        file_size_reg = '0;
        window_reg    = WINDOW_RESET;
        timeout_reg   = TIMEOUT_RESET;
        base_seq      = '0;
        next_unsent   = '0;
        idle_ticks    = '0;
        last_ack      = '0;
        last_ack_seen = 1'b0;
        dup_acks      = '0;
        fast_pending  = 1'b0;
        transfer_over = 1'b0;

        // Out of reset the file is empty, so the header is the whole transfer.
        script.push_back(hand_row(OP_TICK, 16'h0000, 1'b0, 1'b1,
                                  lone_seg(16'd0, 24'd0, 11'd0, 1'b1, 1'b0)));
        script.push_back(hand_row(OP_TICK, 16'hFFFF, 1'b1, 1'b0, '0));
        // With a zero timeout every tick resends, here just the header.
        script.push_back(reg_row(REG_TIMEOUT_TICKS, 32'd0));
        script.push_back(hand_row(OP_TICK, 16'h0000, 1'b0, 1'b1,
                                  lone_seg(16'd0, 24'd0, 11'd0, 1'b1, 1'b1)));
        // A zero window is clamped to one, and the timer is pushed to its top.
        script.push_back(reg_row(REG_WINDOW_SIZE, 32'd0));
        script.push_back(reg_row(REG_FILE_SIZE, 32'd3000));
        script.push_back(reg_row(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF));
        script.push_back(hand_row(OP_TICK, 16'h0000, 1'b0, 1'b0, '0));
        // Bad checksum is dropped.
        script.push_back(hand_row(OP_ACK, 16'h0000, 1'b0, 1'b0, '0));
        script.push_back(ev_row(OP_ACK, 16'h0000, 1'b1));
        script.push_back(ev_row(OP_TICK, 16'h0000, 1'b0));
        // An oversized window is clamped to the cap; the second tick sends the
        // partial segment and the third finds nothing left to send.
        script.push_back(reg_row(REG_WINDOW_SIZE, 32'd63));
        script.push_back(ev_row(OP_TICK, 16'h0000, 1'b0));
        script.push_back(ev_row(OP_TICK, 16'h0000, 1'b0));
        script.push_back(ev_row(OP_TICK, 16'h0000, 1'b0));
        // Acks for segments never sent are dropped.
        script.push_back(hand_row(OP_ACK, 16'd4, 1'b1, 1'b0, '0));
        script.push_back(hand_row(OP_ACK, 16'hFFFF, 1'b1, 1'b0, '0));
        // Four identical acks arm the fast retransmit, a fifth does not rearm.
        repeat (5) script.push_back(ev_row(OP_ACK, 16'd1, 1'b1));
        script.push_back(ev_row(OP_TICK, 16'h0000, 1'b0));
        script.push_back(ev_row(OP_TICK, 16'h0000, 1'b0));
        // Stale ack below the base.
        script.push_back(ev_row(OP_ACK, 16'd0, 1'b1));
        // Largest file.
        script.push_back(reg_row(REG_FILE_SIZE, 32'h00FF_FFFF));
        script.push_back(ev_row(OP_TICK, 16'h0000, 1'b0));
        script.push_back(hand_row(OP_ACK, 16'hFFFF, 1'b0, 1'b0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (script[i]) begin
            row = script[i];
            if (row.write_reg) begin
                // Registers are only written while the block has nothing in flight.
                if (!prev_cfg) wait_idle();
                write_reg(row.reg_sel, row.reg_value);
            end else begin
                cfg_ch.valid <= 1'b0;
                send_event(row.ev, row.by_hand, row.hand_count, row.hand_seg);
            end
            prev_cfg = row.write_reg;
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            cfg_ch.valid <= 1'b0;
            idle_mode = idle_mode_t'(ph % 4);

            // Keep the transfer open: the new file always ends a few segments
            // past what has been sent, with or without a partial segment.
            target = next_unsent + ((ph == PRESSURE_PH) ? 30 : $urandom_range(2, 30));
            if ($urandom_range(0, 1))
                fsize = (target - 1) * SEG_BYTES;
            else
                fsize = (target - 2) * SEG_BYTES + $urandom_range(1, SEG_BYTES - 1);

            case ($urandom_range(0, 5))
                0:       win = 0;
                1:       win = 63;
                2:       win = WINDOW_CAP;
                default: win = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       tmo = 0;
                1:       tmo = 32'hFFFF_FFFF;
                default: tmo = $urandom_range(1, 10);
            endcase

            // The pressure phase resends a full window on every tick while the
            // result side is held off, so the block backs up into its input.
            if (ph == PRESSURE_PH) begin
                win       = WINDOW_CAP;
                tmo       = 1;
                idle_mode = IDLE_NONE;
            end

            write_reg(REG_FILE_SIZE, fsize);
            write_reg(REG_WINDOW_SIZE, win);
            write_reg(REG_TIMEOUT_TICKS, tmo);
            if (ph == PRESSURE_PH) hold_asked++;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Once, the sender waits mid-phase for every owed segment.
                if (ph == PAUSE_PH && k == PHASE_ITEMS / 2) wait_idle();
                else cfg_ch.valid <= 1'b0;
                ev = pick_event(1'b0);
                send_event(ev, 1'b0, 1'b0, '0);
            end
        end

        // Closing phase: a short file past the current position, acks allowed
        // to reach the final segment, and a few events after done that the
        // block must swallow without answering.
        wait_idle();
        idle_mode = IDLE_SENDER;
        write_reg(REG_FILE_SIZE, (next_unsent + 2) * SEG_BYTES);
        write_reg(REG_WINDOW_SIZE, 32'd8);
        write_reg(REG_TIMEOUT_TICKS, 32'd3);
        guard = 0;
        while (!transfer_over && guard < FINALE_GUARD) begin
            cfg_ch.valid <= 1'b0;
            ev = pick_event(1'b1);
            send_event(ev, 1'b0, 1'b0, '0);
            guard++;
        end
        repeat (4) begin
            cfg_ch.valid <= 1'b0;
            ev = pick_event(1'b1);
            send_event(ev, 1'b0, 1'b0, '0);
        end

        item_ch.valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake or a segment that never comes out.
    initial begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/gbn_pkg.sv
rtl/gbn_ifs.sv
rtl/gbn_ctrl.sv
rtl/gbn_datapath.sv
rtl/go_back_n_sender_window.sv
rtl/gbn_checker.sv
bench/go_back_n_sender_window_test.sv
